// ===== design/local_alignment_affine_fill_top_assert.svh =====
// Assertion macros for the local alignment fill block.
// Used by local_alignment_affine_fill_top; expects clk and arst_n in scope.
`ifndef LOCAL_ALIGNMENT_AFFINE_FILL_TOP_ASSERT_SVH
`define LOCAL_ALIGNMENT_AFFINE_FILL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define LAF_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("lafill: assertion failed");
// checked at every edge, reset included
`define LAF_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("lafill: reset assertion failed");
`else
`define LAF_ASSERT(lbl, prop)
`define LAF_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/lafill_pkg.sv =====
// Shared types and constants for the local alignment fill block.
// No dependencies.
`default_nettype none
package lafill_pkg;
	localparam int MAX_ROWS_DEF    = 4096;
	localparam int MAX_COLS_DEF    = 1024;
	localparam int SCORE_WIDTH_DEF = 24;

	localparam int APB_ADDR_W = 4;

	localparam logic [1:0] REG_GAP_OPEN   = 2'd0;
	localparam logic [1:0] REG_GAP_EXTEND = 2'd1;
	localparam logic [1:0] REG_ROWS       = 2'd2;
	localparam logic [1:0] REG_COLS       = 2'd3;

	localparam logic signed [15:0] GAP_OPEN_RST   = -16'sd2560;
	localparam logic signed [15:0] GAP_EXTEND_RST = -16'sd256;
	localparam logic [12:0]        ROWS_RST       = 13'd1;
	localparam logic [10:0]        COLS_RST       = 11'd1;

	localparam logic [1:0] SRC_DIAG    = 2'd0;
	localparam logic [1:0] SRC_DELETE  = 2'd1;
	localparam logic [1:0] SRC_INSERT  = 2'd2;
	localparam logic [1:0] SRC_RESTART = 2'd3;

	typedef struct packed {
		logic first_row;
		logic row_end;
		logic mat_end;
	} cell_flags_t;

	typedef struct packed {
		logic [1:0]  trace_source;
		logic        delete_opened;
		logic        insert_opened;
		logic        found;
		logic [22:0] best_score;
		logic [12:0] best_end_row;
		logic [10:0] best_end_col;
	} cell_res_t;
endpackage
`default_nettype wire

// ===== design/lafill_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lafill_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/lafill_cfg.sv =====
// APB register file: gap penalties and matrix size.
// Depends on lafill_pkg.
`default_nettype none
module lafill_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [lafill_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                      pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	output logic signed [15:0]                    gap_open,
	output logic signed [15:0]                    gap_extend,
	output logic [12:0]                           rows_in_use,
	output logic [10:0]                           cols_in_use
);
	import lafill_pkg::*;

	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open    <= GAP_OPEN_RST;
			gap_extend  <= GAP_EXTEND_RST;
			rows_in_use <= ROWS_RST;
			cols_in_use <= COLS_RST;
		end else if (wr) begin
			unique case (idx)
				REG_GAP_OPEN:   gap_open    <= pwdata[15:0];
				REG_GAP_EXTEND: gap_extend  <= pwdata[15:0];
				REG_ROWS:       rows_in_use <= pwdata[12:0];
				REG_COLS:       cols_in_use <= pwdata[10:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAP_OPEN:   prdata = {16'd0, gap_open};
			REG_GAP_EXTEND: prdata = {16'd0, gap_extend};
			REG_ROWS:       prdata = {19'd0, rows_in_use};
			REG_COLS:       prdata = {21'd0, cols_in_use};
		endcase
	end
endmodule
`default_nettype wire

// ===== design/lafill_seq.sv =====
// Cell position sequencer: row/column counters, size clamping, row and matrix end.
// Depends on lafill_pkg.
`default_nettype none
module lafill_seq #(
	parameter int MAX_ROWS = lafill_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lafill_pkg::MAX_COLS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [12:0]                 rows_in_use,
	input  wire logic [10:0]                 cols_in_use,
	output logic [$clog2(MAX_ROWS)-1:0]      cur_row,
	output logic [$clog2(MAX_COLS)-1:0]      cur_col,
	output lafill_pkg::cell_flags_t          cur_flags
);
	import lafill_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	logic [RW-1:0] row_q, last_row;
	logic [CW-1:0] col_q, last_col;
	logic [31:0]   nrows, ncols;

	// zero counts as one, oversize saturates
	always_comb begin
		if (rows_in_use == '0) begin
			nrows = 32'd1;
		end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
			nrows = 32'(MAX_ROWS);
		end else begin
			nrows = 32'(rows_in_use);
		end
		if (cols_in_use == '0) begin
			ncols = 32'd1;
		end else if (32'(cols_in_use) > 32'(MAX_COLS)) begin
			ncols = 32'(MAX_COLS);
		end else begin
			ncols = 32'(cols_in_use);
		end
	end

	assign last_row = RW'(nrows - 32'd1);
	assign last_col = CW'(ncols - 32'd1);

	// a counter past a shrunk size behaves as the last index
	assign cur_row = (row_q >= last_row) ? last_row : row_q;
	assign cur_col = (col_q >= last_col) ? last_col : col_q;

	assign cur_flags.first_row = (cur_row == '0);
	assign cur_flags.row_end   = (cur_col == last_col);
	assign cur_flags.mat_end   = cur_flags.row_end && (cur_row == last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			if (cur_flags.mat_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (cur_flags.row_end) begin
				row_q <= cur_row + RW'(1);
				col_q <= '0;
			end else begin
				row_q <= cur_row;
				col_q <= cur_col + CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/lafill_cell.sv =====
// Cell recurrence: match/delete/insert update, insert and diagonal registers,
// best score tracking. Depends on lafill_pkg.
`default_nettype none
module lafill_cell #(
	parameter int MAX_ROWS    = lafill_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = lafill_pkg::MAX_COLS_DEF,
	parameter int SCORE_WIDTH = lafill_pkg::SCORE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           fire,
	input  wire lafill_pkg::cell_flags_t        flags,
	input  wire logic [$clog2(MAX_ROWS)-1:0]    row,
	input  wire logic [$clog2(MAX_COLS)-1:0]    col,
	input  wire logic signed [15:0]             score,
	input  wire logic signed [SCORE_WIDTH-1:0]  above_m,
	input  wire logic signed [SCORE_WIDTH-1:0]  above_d,
	input  wire logic signed [15:0]             gap_open,
	input  wire logic signed [15:0]             gap_extend,
	output logic signed [SCORE_WIDTH-1:0]       match_new,
	output logic signed [SCORE_WIDTH-1:0]       delete_new,
	output lafill_pkg::cell_res_t               res
);
	import lafill_pkg::*;

	localparam int W  = SCORE_WIDTH;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam logic signed [W-1:0] NEG_INF = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] ZERO    = '0;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [15:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {{(W-15){b[15]}}, b};
		if (s[W] != s[W-1]) begin
			return s[W] ? NEG_INF : POS_MAX;
		end
		return s[W-1:0];
	endfunction

	logic signed [W-1:0] insert_q, diag_q, best_q;
	logic [RW-1:0]       best_row_q;
	logic [CW-1:0]       best_col_q;

	logic signed [W-1:0] x, md, dn, in_ext, insert_new, best_n;
	logic [1:0]          src;
	logic                dopen, iopen, better, found;
	logic [RW-1:0]       best_row_n;
	logic [CW-1:0]       best_col_n;
	logic [31:0]         bs32, br32, bc32;

	always_comb begin
		x   = diag_q;
		src = SRC_DIAG;
		if (above_d > x) begin
			x   = above_d;
			src = SRC_DELETE;
		end
		if (insert_q > x) begin
			x   = insert_q;
			src = SRC_INSERT;
		end
		if (x <= ZERO) begin
			x   = ZERO;
			src = SRC_RESTART;
		end
	end

	assign match_new = sat_add(x, score);

	// ties go to gap open
	assign md         = sat_add(diag_q, gap_open);
	assign dn         = sat_add(above_d, gap_extend);
	assign dopen      = (md >= dn);
	assign delete_new = dopen ? md : dn;
	assign in_ext     = sat_add(insert_q, gap_extend);
	assign iopen      = (md >= in_ext);
	assign insert_new = iopen ? md : in_ext;

	assign better     = (match_new > best_q);
	assign best_n     = better ? match_new : best_q;
	assign best_row_n = better ? row : best_row_q;
	assign best_col_n = better ? col : best_col_q;
	assign found      = flags.mat_end && (best_n > ZERO);

	assign bs32 = 32'(best_n);
	assign br32 = 32'(best_row_n) + 32'd1;
	assign bc32 = 32'(best_col_n) + 32'd1;

	assign res.trace_source  = src;
	assign res.delete_opened = dopen;
	assign res.insert_opened = iopen;
	assign res.found         = found;
	assign res.best_score    = found ? bs32[22:0] : '0;
	assign res.best_end_row  = found ? br32[12:0] : '0;
	assign res.best_end_col  = found ? bc32[10:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			insert_q   <= NEG_INF;
			diag_q     <= ZERO;
			best_q     <= ZERO;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (fire) begin
			if (flags.mat_end) begin
				insert_q   <= NEG_INF;
				diag_q     <= ZERO;
				best_q     <= ZERO;
				best_row_q <= '0;
				best_col_q <= '0;
			end else begin
				best_q     <= best_n;
				best_row_q <= best_row_n;
				best_col_q <= best_col_n;
				if (flags.row_end) begin
					insert_q <= NEG_INF;
					diag_q   <= NEG_INF;
				end else begin
					insert_q <= insert_new;
					diag_q   <= above_m;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/local_alignment_affine_fill_top.sv =====
// Top level of the affine-gap local alignment matrix fill.
// Depends on lafill_pkg, lafill_cfg, lafill_seq, lafill_cell, lafill_ram and the assertion header.
//
//  channel  | signals                               | direction | beat
//  ---------+---------------------------------------+-----------+------------------------
//  in       | in_valid, in_stall, match_score        | to block  | one matrix cell score
//  out      | out_valid, out_stall, trace/pos/best   | from block| trace bits of that cell
//  apb      | psel..pwdata, prdata, pready           | both      | one register access
//
// One cell per clock sustained while the output is not stalled; a beat passes the cell
// stage and then the result register. The loop that sets the rate is the insert value:
// max, saturating add, compare and select. Row memories are read at accept, ahead of
// the cell stage; the write of the previous cell is forwarded when the columns match.
// Reset clears counters, pipeline valids and the running values; the row
// memories are not cleared, row zero reads them as minus infinity.
// A stalled output holds the result register and stalls the input only once
// the cell stage is also full.
`default_nettype none
`include "local_alignment_affine_fill_top_assert.svh"
module local_alignment_affine_fill_top #(
	parameter int MAX_ROWS    = lafill_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = lafill_pkg::MAX_COLS_DEF,
	parameter int SCORE_WIDTH = lafill_pkg::SCORE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lafill_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	// cell input
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [15:0]                match_score,
	// cell result
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             trace_source,
	output logic                                   delete_opened,
	output logic                                   insert_opened,
	output logic [11:0]                            cell_row,
	output logic [9:0]                             cell_col,
	output logic                                   last_cell,
	output logic                                   found,
	output logic [22:0]                            best_score,
	output logic [12:0]                            best_end_row,
	output logic [10:0]                            best_end_col
);
	import lafill_pkg::*;

	localparam int W  = SCORE_WIDTH;
	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam logic signed [W-1:0] NEG_INF = {1'b1, {(W-1){1'b0}}};

	logic signed [15:0] gap_open, gap_extend;
	logic [12:0]        rows_in_use;
	logic [10:0]        cols_in_use;

	logic [RW-1:0] cur_row;
	logic [CW-1:0] cur_col;
	cell_flags_t   cur_flags;

	// cell stage
	logic               s1_valid_q;
	logic signed [15:0] score_s1;
	logic [RW-1:0]      row_s1;
	logic [CW-1:0]      col_s1;
	cell_flags_t        flags_s1;
	logic               fwd_s1;
	logic [W-1:0]       fwd_m_s1, fwd_d_s1;

	logic         in_accept, s1_fire, out_take, ram_we;
	logic [W-1:0] rd_m, rd_d;
	logic signed [W-1:0] above_m, above_d, match_new, delete_new;
	cell_res_t    res;
	logic [31:0]  row32, col32;

	lafill_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.gap_open, .gap_extend, .rows_in_use, .cols_in_use
	);

	lafill_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
		.clk, .arst_n, .advance(in_accept), .rows_in_use, .cols_in_use,
		.cur_row, .cur_col, .cur_flags
	);

	// handshake: the cell stage fires when the output register is empty or being taken
	assign out_take  = out_valid && !out_stall;
	assign s1_fire   = s1_valid_q && (!out_valid || !out_stall);
	assign in_stall  = s1_valid_q && !s1_fire;
	assign in_accept = in_valid && !in_stall;
	assign ram_we    = s1_fire;

	lafill_ram #(.WIDTH(W), .DEPTH(MAX_COLS)) u_match_row (
		.clk, .we(ram_we), .waddr(col_s1), .wdata(match_new),
		.re(in_accept), .raddr(cur_col), .rdata(rd_m)
	);

	lafill_ram #(.WIDTH(W), .DEPTH(MAX_COLS)) u_delete_row (
		.clk, .we(ram_we), .waddr(col_s1), .wdata(delete_new),
		.re(in_accept), .raddr(cur_col), .rdata(rd_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// payload of the cell stage; the forward copy covers a write and a read
	// of the same column at one edge (single-column matrices)
	always_ff @(posedge clk) begin
		if (in_accept) begin
			score_s1 <= match_score;
			row_s1   <= cur_row;
			col_s1   <= cur_col;
			flags_s1 <= cur_flags;
			fwd_s1   <= ram_we && (col_s1 == cur_col);
			fwd_m_s1 <= match_new;
			fwd_d_s1 <= delete_new;
		end
	end

	// row zero sees minus infinity above
	always_comb begin
		if (flags_s1.first_row) begin
			above_m = NEG_INF;
			above_d = NEG_INF;
		end else if (fwd_s1) begin
			above_m = fwd_m_s1;
			above_d = fwd_d_s1;
		end else begin
			above_m = rd_m;
			above_d = rd_d;
		end
	end

	lafill_cell #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .SCORE_WIDTH(W)) u_cell (
		.clk, .arst_n, .fire(s1_fire), .flags(flags_s1), .row(row_s1), .col(col_s1),
		.score(score_s1), .above_m, .above_d, .gap_open, .gap_extend,
		.match_new, .delete_new, .res
	);

	assign row32 = 32'(row_s1);
	assign col32 = 32'(col_s1);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_fire) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			trace_source  <= res.trace_source;
			delete_opened <= res.delete_opened;
			insert_opened <= res.insert_opened;
			cell_row      <= row32[11:0];
			cell_col      <= col32[9:0];
			last_cell     <= flags_s1.mat_end;
			found         <= res.found;
			best_score    <= res.best_score;
			best_end_row  <= res.best_end_row;
			best_end_col  <= res.best_end_col;
		end
	end

	// an edge in reset leaves both valids clear at the next edge
	`LAF_ASSERT_RST(a_reset_quiet, !arst_n |=> (!out_valid && !s1_valid_q))
	`LAF_ASSERT(a_stall_when_full, (s1_valid_q && out_valid && out_stall) |-> in_stall)
	`LAF_ASSERT(a_fwd_capture, (in_accept && ram_we && (col_s1 == cur_col)) |=> fwd_s1)
	`LAF_ASSERT(a_wrap_after_last, (in_accept && cur_flags.mat_end) |=> (cur_row == '0 && cur_col == '0))
endmodule
`default_nettype wire

// ===== tb/local_alignment_affine_fill_top_test.sv =====
// Self-checking bench for local_alignment_affine_fill_top: directed cells, size extremes
// and random matrices, each beat checked against an in-bench scorer or a hand-written result.
// Depends on lafill_pkg and the block under test only.
`default_nettype none
module local_alignment_affine_fill_top_test;
	import lafill_pkg::*;

	localparam int SW    = SCORE_WIDTH_DEF;
	localparam int MAX_R = MAX_ROWS_DEF;
	localparam int MAX_C = MAX_COLS_DEF;
	localparam longint NEG_INF = -(longint'(1) << (SW - 1));
	localparam longint POS_MAX = (longint'(1) << (SW - 1)) - 1;
	localparam int HOLD_CYCLES = 150;
	localparam int STRETCH     = 96;

	// one result beat, field for field as it leaves the block
	typedef struct packed {
		logic [1:0]  src;
		logic        dopen;
		logic        iopen;
		logic [11:0] row;
		logic [9:0]  col;
		logic        last;
		logic        found;
		logic [22:0] best;
		logic [12:0] brow;
		logic [10:0] bcol;
	} cell_out_t;

	// directed table row: a register write or a cell, the latter optionally with a
	// hand-written result
	typedef struct {
		bit                 is_reg;
		logic [1:0]         idx;
		logic [31:0]        val;
		logic signed [15:0] score;
		bit                 known;
		cell_out_t          want;
	} plan_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]        paddr = '0;
	logic [31:0]                  pwdata = '0;
	wire logic [31:0]             prdata;
	wire logic                    pready;
	logic                         in_valid = 1'b0;
	wire logic                    in_stall;
	logic signed [15:0]           match_score = '0;
	wire logic                    out_valid;
	logic                         out_stall = 1'b0;
	wire logic [1:0]              trace_source;
	wire logic                    delete_opened;
	wire logic                    insert_opened;
	wire logic [11:0]             cell_row;
	wire logic [9:0]              cell_col;
	wire logic                    last_cell;
	wire logic                    found;
	wire logic [22:0]             best_score;
	wire logic [12:0]             best_end_row;
	wire logic [10:0]             best_end_col;

	local_alignment_affine_fill_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.match_score   (match_score),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.trace_source  (trace_source),
		.delete_opened (delete_opened),
		.insert_opened (insert_opened),
		.cell_row      (cell_row),
		.cell_col      (cell_col),
		.last_cell     (last_cell),
		.found         (found),
		.best_score    (best_score),
		.best_end_row  (best_end_row),
		.best_end_col  (best_end_col)
	);

	// 10 unit clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit: well over ten times the expected length of a clean run
	initial begin
		#8_000_000;
		$display("local_alignment_affine_fill_top_test: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Scorer state: register copies, the two row memories and the running values
	// ---------------------------------------------------------------------------------
	logic signed [15:0]   gap_open_set   = GAP_OPEN_RST;
	logic signed [15:0]   gap_extend_set = GAP_EXTEND_RST;
	logic [12:0]          rows_set       = ROWS_RST;
	logic [10:0]          cols_set       = COLS_RST;
	logic signed [SW-1:0] match_mem  [MAX_C];
	logic signed [SW-1:0] delete_mem [MAX_C];
	logic signed [SW-1:0] ins_run    = SW'(NEG_INF);
	logic signed [SW-1:0] diag_held  = '0;
	logic signed [SW-1:0] best_held  = '0;
	logic [11:0]          best_r     = '0;
	logic [9:0]           best_c     = '0;
	logic [11:0]          row_pos    = '0;
	logic [9:0]           col_pos    = '0;

	cell_out_t cells_due[$];   // results still owed by the block, oldest first
	plan_row_t plan[$];
	int        errors = 0;
	bit        no_idle = 1'b0;
	int        hold_requests = 0;

	function automatic longint sat(longint v);
		if (v < NEG_INF)
			return NEG_INF;
		if (v > POS_MAX)
			return POS_MAX;
		return v;
	endfunction

	// zero counts as one, oversize clamps to the size limit
	function automatic int unsigned eff_size(int unsigned v, int unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic void new_matrix();
		ins_run   = SW'(NEG_INF);
		diag_held = '0;
		best_held = '0;
		best_r    = '0;
		best_c    = '0;
		row_pos   = '0;
		col_pos   = '0;
	endfunction

	// Scores one cell and advances the position; returns the beat the block owes.
	function automatic cell_out_t fill_cell(logic signed [15:0] s);
		int unsigned nr, nc, r, c;
		longint      up_m, up_d, dg, x, open_v, del_ext, ins_ext;
		cell_out_t   o;
		nr = eff_size(rows_set, MAX_R);
		nc = eff_size(cols_set, MAX_C);
		r  = (row_pos >= nr) ? nr - 1 : row_pos;
		c  = (col_pos >= nc) ? nc - 1 : col_pos;
		o      = '0;
		o.row  = 12'(r);
		o.col  = 10'(c);
		o.last = (c == nc - 1) && (r == nr - 1);
		// row zero has nothing above it
		up_m = (r == 0) ? NEG_INF : longint'(match_mem[c]);
		up_d = (r == 0) ? NEG_INF : longint'(delete_mem[c]);
		dg   = longint'(diag_held);
		// predecessor: later candidates need to be strictly greater
		x     = dg;
		o.src = SRC_DIAG;
		if (up_d > x) begin
			x     = up_d;
			o.src = SRC_DELETE;
		end
		if (longint'(ins_run) > x) begin
			x     = longint'(ins_run);
			o.src = SRC_INSERT;
		end
		if (x <= 0) begin
			x     = 0;
			o.src = SRC_RESTART;
		end
		x = sat(x + longint'(s));
		if (x > longint'(best_held)) begin
			best_held = SW'(x);
			best_r    = 12'(r);
			best_c    = 10'(c);
		end
		match_mem[c] = SW'(x);
		// gaps: opening wins ties
		open_v        = sat(dg + longint'(gap_open_set));
		del_ext       = sat(up_d + longint'(gap_extend_set));
		ins_ext       = sat(longint'(ins_run) + longint'(gap_extend_set));
		o.dopen       = (open_v >= del_ext);
		o.iopen       = (open_v >= ins_ext);
		delete_mem[c] = SW'(o.dopen ? open_v : del_ext);
		ins_run       = SW'(o.iopen ? open_v : ins_ext);
		diag_held     = SW'(up_m);
		if (o.last && best_held > 0) begin
			o.found = 1'b1;
			o.best  = 23'(best_held);
			o.brow  = 13'(best_r) + 13'd1;
			o.bcol  = 11'(best_c) + 11'd1;
		end
		if (o.last) begin
			new_matrix();
		end else if (c == nc - 1) begin
			row_pos   = 12'(r + 1);
			col_pos   = '0;
			diag_held = SW'(NEG_INF);
			ins_run   = SW'(NEG_INF);
		end else begin
			row_pos = 12'(r);
			col_pos = 10'(c + 1);
		end
		return o;
	endfunction

	// ---------------------------------------------------------------------------------
	// Bus side helpers
	// ---------------------------------------------------------------------------------
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_GAP_OPEN:   gap_open_set   = val[15:0];
			REG_GAP_EXTEND: gap_extend_set = val[15:0];
			REG_ROWS:       rows_set       = val[12:0];
			REG_COLS:       cols_set       = val[10:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// offers one cell beat; scores it at the edge where it is taken
	task automatic send_cell(input logic signed [15:0] s, input bit known,
			input cell_out_t typed, output bit last);
		cell_out_t want;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		match_score <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		want = fill_cell(s);
		if (known)
			want = typed;
		cells_due.push_back(want);
		last = want.last;
	endtask

	// drops valid and waits until every owed beat is in, then idles on
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_score();
		case ($urandom_range(9))
			0: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
			1, 2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(2047)) - 1024);
		endcase
	endfunction

	function automatic int rand_gap();
		case ($urandom_range(7))
			0: return 0;
			1: return -32768;
			2: return -int'($urandom_range(32768));
			default: return -256 * int'($urandom_range(12)) - int'($urandom_range(255));
		endcase
	endfunction

	function automatic int unsigned rand_size();
		case ($urandom_range(19))
			0: return 0;
			1, 2: return $urandom_range(20, 7);
			default: return $urandom_range(6, 1);
		endcase
	endfunction

	function automatic void plan_reg(logic [1:0] idx, logic [31:0] val);
		plan_row_t p;
		p        = '{default: '0};
		p.is_reg = 1'b1;
		p.idx    = idx;
		p.val    = val;
		plan.push_back(p);
	endfunction

	function automatic void plan_cell(logic signed [15:0] s);
		plan_row_t p;
		p       = '{default: '0};
		p.score = s;
		plan.push_back(p);
	endfunction

	// a lone 1x1 matrix: always a restart with both gaps opened, position 0,0
	function automatic void plan_known(logic signed [15:0] s, bit f, logic [22:0] b);
		plan_row_t p;
		p            = '{default: '0};
		p.score      = s;
		p.known      = 1'b1;
		p.want       = '0;
		p.want.src   = SRC_RESTART;
		p.want.dopen = 1'b1;
		p.want.iopen = 1'b1;
		p.want.last  = 1'b1;
		p.want.found = f;
		p.want.best  = b;
		p.want.brow  = f ? 13'd1 : 13'd0;
		p.want.bcol  = f ? 11'd1 : 11'd0;
		plan.push_back(p);
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------------------------
	// Result side: random stalls, plus a long hold-off on request
	// ---------------------------------------------------------------------------------
	int hold_left = 0;
	int holds_served = 0;

	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 27);
		end
	end

	always @(posedge clk) begin : beat_check
		cell_out_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (cells_due.size() == 0) begin
				$error("result beat with nothing owed: row %0d col %0d", cell_row, cell_col);
				errors++;
			end else begin
				want = cells_due.pop_front();
				check_field("trace_source",  want.src,   trace_source);
				check_field("delete_opened", want.dopen, delete_opened);
				check_field("insert_opened", want.iopen, insert_opened);
				check_field("cell_row",      want.row,   cell_row);
				check_field("cell_col",      want.col,   cell_col);
				check_field("last_cell",     want.last,  last_cell);
				check_field("found",         want.found, found);
				check_field("best_score",    want.best,  best_score);
				check_field("best_end_row",  want.brow,  best_end_row);
				check_field("best_end_col",  want.bcol,  best_end_col);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------
	initial begin : stimulus
		bit          last;
		int          random_cells;
		int          matrix_no;
		int          n;
		int          noise_at;
		int unsigned total;
		int unsigned r_sz;
		int unsigned c_sz;

		random_cells = 0;
		matrix_no    = 0;
		new_matrix();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset sizes give 1x1 matrices: result readable straight off the score
		plan_known(16'sd0, 1'b0, 23'd0);
		plan_known(16'sd1, 1'b1, 23'd1);
		plan_known(-16'sd1, 1'b0, 23'd0);
		plan_known(16'sh7FFF, 1'b1, 23'd32767);
		plan_known(16'sh8000, 1'b0, 23'd0);
		plan_known(16'sh5555, 1'b1, 23'd21845);
		plan_known(16'shAAAA, 1'b0, 23'd0);
		// zero sizes count as one
		plan_reg(REG_ROWS, 32'd0);
		plan_reg(REG_COLS, 32'd0);
		plan_known(16'sd256, 1'b1, 23'd256);
		plan_known(-16'sd256, 1'b0, 23'd0);
		// free gaps: ties everywhere
		plan_reg(REG_GAP_OPEN, 32'd0);
		plan_reg(REG_GAP_EXTEND, 32'd0);
		plan_reg(REG_ROWS, 32'd2);
		plan_reg(REG_COLS, 32'd2);
		plan_cell(16'sd256);
		plan_cell(16'sd256);
		plan_cell(16'sd256);
		plan_cell(16'sd256);
		// harshest gaps, extreme scores
		plan_reg(REG_GAP_OPEN, -32'sd32768);
		plan_reg(REG_GAP_EXTEND, -32'sd32768);
		plan_reg(REG_ROWS, 32'd2);
		plan_reg(REG_COLS, 32'd3);
		plan_cell(16'sh7FFF);
		plan_cell(16'sh8000);
		plan_cell(16'sd500);
		plan_cell(-16'sd1);
		plan_cell(16'sh7FFF);
		plan_cell(16'sd0);
		// shrink both sizes in mid-matrix: position clamps onto the new last cell
		plan_reg(REG_GAP_OPEN, -32'sd512);
		plan_reg(REG_GAP_EXTEND, -32'sd128);
		plan_reg(REG_ROWS, 32'd3);
		plan_reg(REG_COLS, 32'd3);
		plan_cell(16'sd1000);
		plan_cell(-16'sd300);
		plan_cell(16'sd700);
		plan_cell(16'sd200);
		plan_cell(-16'sd50);
		plan_reg(REG_COLS, 32'd1);
		plan_reg(REG_ROWS, 32'd1);
		plan_cell(16'sd900);
		plan_cell(16'sd300);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				reg_write(plan[i].idx, plan[i].val);
			end else begin
				send_cell(plan[i].score, plan[i].known, plan[i].want, last);
			end
		end

		// oversize rows: one past the limit must clamp, not wrap to a single row;
		// run down the first rows with no idling on either side, then shrink to close
		settle();
		no_idle = 1'b1;
		reg_write(REG_ROWS, 32'(MAX_R + 1));
		reg_write(REG_COLS, 32'd1);
		for (int i = 0; i < STRETCH; i++)
			send_cell(16'(int'($urandom_range(2047)) - 1024), 1'b0, '0, last);
		settle();
		reg_write(REG_ROWS, 32'd1);
		send_cell(16'sh7FFF, 1'b0, '0, last);

		// oversize columns: same along row zero
		settle();
		reg_write(REG_COLS, 32'(MAX_C + 1));
		for (int i = 0; i < STRETCH; i++)
			send_cell(16'(int'($urandom_range(2047)) - 1024), 1'b0, '0, last);
		settle();
		reg_write(REG_COLS, 32'd1);
		send_cell(16'sh7FFF, 1'b0, '0, last);
		settle();
		no_idle = 1'b0;

		// random matrices; now and then a size is rewritten mid-matrix
		while (random_cells < 480) begin
			settle();
			r_sz = rand_size();
			c_sz = rand_size();
			if (matrix_no == 4) begin
				// sink holds off while cells keep coming: the block backs up
				hold_requests++;
				r_sz = 8;
				c_sz = 8;
			end
			reg_write(REG_GAP_OPEN, 32'(rand_gap()));
			reg_write(REG_GAP_EXTEND, 32'(rand_gap()));
			reg_write(REG_ROWS, 32'(r_sz));
			reg_write(REG_COLS, 32'(c_sz));
			total    = eff_size(r_sz, MAX_R) * eff_size(c_sz, MAX_C);
			noise_at = ($urandom_range(9) == 0 && total > 2) ? $urandom_range(total - 1, 1) : 0;
			n        = 0;
			do begin
				send_cell(rand_score(), 1'b0, '0, last);
				n++;
				random_cells++;
				if (!last && n == noise_at) begin
					settle();
					// columns may only grow in row zero, else a later row would read
					// entries never written
					if ($urandom_range(1) != 0)
						reg_write(REG_ROWS, 32'($urandom_range(8)));
					else if (row_pos == 0)
						reg_write(REG_COLS, 32'($urandom_range(8)));
					else
						reg_write(REG_COLS, 32'($urandom_range(eff_size(cols_set, MAX_C))));
				end
			end while (!last);
			matrix_no++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("local_alignment_affine_fill_top_test: done, clean");
		else
			$display("local_alignment_affine_fill_top_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
